// File: src/obm_pkg.sv
package obm_pkg;

   // Widths of the transaction fields
   localparam int REQ_TYPE_W   = 2;
   localparam int BIT_COUNT_W  = 4;
   localparam int BYTE_W       = 8;
   localparam int PIN_MODE_W   = 2;
   localparam int STATUS_W     = 2;
   localparam int TIMER_W      = 10;

   // Longest transfer in bits; longer requests are cut down to this
   localparam int MAX_BITS     = 8;

   // Configuration port
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESET = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd3;

   // Pin modes
   localparam logic [PIN_MODE_W-1:0] PIN_RELEASED = 2'd0;
   localparam logic [PIN_MODE_W-1:0] PIN_LOW      = 2'd1;
   localparam logic [PIN_MODE_W-1:0] PIN_HIGH     = 2'd2;

   // Completion status
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PRESENCE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED    = 2'd2;

   typedef struct packed {
      logic [7:0] recovery_ticks;
      logic [3:0] low_pulse_ticks;
      logic [5:0] sample_delay_ticks;
      logic [7:0] slot_ticks;
      logic [9:0] reset_low_ticks;
      logic [7:0] presence_delay_ticks;
      logic [9:0] reset_tail_ticks;
   } cfg_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]  req_type;
      logic [BIT_COUNT_W-1:0] bit_count;
      logic [BYTE_W-1:0]      write_byte;
      logic                   bus_level;
   } req_item_type;

   typedef struct packed {
      logic [PIN_MODE_W-1:0] pin_mode;
      logic                  busy_res;
      logic                  done_res;
      logic [BYTE_W-1:0]     read_byte;
      logic [STATUS_W-1:0]   status;
   } rsp_item_type;

endpackage

// File: src/obm_req_if.sv
interface obm_req_if import obm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [BIT_COUNT_W-1:0] bit_count;
   logic [BYTE_W-1:0]      write_byte;
   logic                   bus_level;

   modport source (output valid, output req_type, output bit_count, output write_byte,
                   output bus_level, input ready);
   modport sink (input valid, input req_type, input bit_count, input write_byte,
                 input bus_level, output ready);
endinterface

// File: src/obm_rsp_if.sv
interface obm_rsp_if import obm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIN_MODE_W-1:0] pin_mode;
   logic                  busy_res;
   logic                  done_res;
   logic [BYTE_W-1:0]     read_byte;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, output pin_mode, output busy_res, output done_res,
                   output read_byte, output status, input ready);
   modport sink (input valid, input pin_mode, input busy_res, input done_res,
                 input read_byte, input status, output ready);
endinterface

// File: src/obm_csr.sv
module obm_csr import obm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   localparam logic [2:0] IDX_RECOVERY    = 3'd0;
   localparam logic [2:0] IDX_LOW_PULSE   = 3'd1;
   localparam logic [2:0] IDX_SAMPLE      = 3'd2;
   localparam logic [2:0] IDX_SLOT        = 3'd3;
   localparam logic [2:0] IDX_RESET_LOW   = 3'd4;
   localparam logic [2:0] IDX_PRESENCE    = 3'd5;
   localparam logic [2:0] IDX_RESET_TAIL  = 3'd6;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            IDX_RECOVERY:   cfg_in.recovery_ticks       = pwdata[7:0];
            IDX_LOW_PULSE:  cfg_in.low_pulse_ticks      = pwdata[3:0];
            IDX_SAMPLE:     cfg_in.sample_delay_ticks   = pwdata[5:0];
            IDX_SLOT:       cfg_in.slot_ticks           = pwdata[7:0];
            IDX_RESET_LOW:  cfg_in.reset_low_ticks      = pwdata[9:0];
            IDX_PRESENCE:   cfg_in.presence_delay_ticks = pwdata[7:0];
            IDX_RESET_TAIL: cfg_in.reset_tail_ticks     = pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.recovery_ticks       <= 8'd2;
         cfg_ff.low_pulse_ticks      <= 4'd3;
         cfg_ff.sample_delay_ticks   <= 6'd7;
         cfg_ff.slot_ticks           <= 8'd60;
         cfg_ff.reset_low_ticks      <= 10'd480;
         cfg_ff.presence_delay_ticks <= 8'd70;
         cfg_ff.reset_tail_ticks     <= 10'd410;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         IDX_RECOVERY:   prdata = CSR_DATA_W'(cfg_ff.recovery_ticks);
         IDX_LOW_PULSE:  prdata = CSR_DATA_W'(cfg_ff.low_pulse_ticks);
         IDX_SAMPLE:     prdata = CSR_DATA_W'(cfg_ff.sample_delay_ticks);
         IDX_SLOT:       prdata = CSR_DATA_W'(cfg_ff.slot_ticks);
         IDX_RESET_LOW:  prdata = CSR_DATA_W'(cfg_ff.reset_low_ticks);
         IDX_PRESENCE:   prdata = CSR_DATA_W'(cfg_ff.presence_delay_ticks);
         IDX_RESET_TAIL: prdata = CSR_DATA_W'(cfg_ff.reset_tail_ticks);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: src/obm_seq.sv
module obm_seq import obm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  cfg_type      cfg,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_RECOVER = 3'd1;
   localparam logic [2:0] PH_LOW     = 3'd2;
   localparam logic [2:0] PH_REST    = 3'd3;
   localparam logic [2:0] PH_RLOW    = 3'd4;
   localparam logic [2:0] PH_RWAIT   = 3'd5;
   localparam logic [2:0] PH_RTAIL   = 3'd6;

   localparam logic [BIT_COUNT_W-1:0] MAX_COUNT = BIT_COUNT_W'(MAX_BITS);
   localparam logic [BIT_COUNT_W-1:0] RX_LIMIT  = BIT_COUNT_W'(BYTE_W);

   logic [2:0]             phase_ff, phase_in;
   logic [TIMER_W-1:0]     timer_ff, timer_in;
   logic [BIT_COUNT_W-1:0] bit_index_ff, bit_index_in;
   logic [BIT_COUNT_W-1:0] bit_total_ff, bit_total_in;
   logic [BYTE_W-1:0]      send_shift_ff, send_shift_in;
   logic [BYTE_W-1:0]      receive_ff, receive_in;
   logic [REQ_TYPE_W-1:0]  op_kind_ff, op_kind_in;

   logic [BIT_COUNT_W-1:0] count_sat;
   logic [3:0]             low_len;
   logic [7:0]             rest_base;
   logic [7:0]             rest_len;
   logic [6:0]             sample_min;
   logic [TIMER_W:0]       phase_len;
   logic [TIMER_W-1:0]     timer_inc;
   logic [BIT_COUNT_W-1:0] index_inc;
   logic [PIN_MODE_W-1:0]  pin;
   logic [STATUS_W-1:0]    st;
   logic                   rejected;
   logic                   fin;
   logic                   empty_done;

   assign count_sat  = (item.bit_count > MAX_COUNT) ? MAX_COUNT : item.bit_count;
   assign low_len    = (cfg.low_pulse_ticks == 4'd0) ? 4'd1 : cfg.low_pulse_ticks;
   assign rest_base  = (cfg.slot_ticks > {4'd0, low_len}) ?
                       cfg.slot_ticks - {4'd0, low_len} : 8'd1;
   assign sample_min = {1'b0, cfg.sample_delay_ticks} + 7'd1;
   // A read slot always lasts long enough to reach its sample point.
   assign rest_len   = (op_kind_ff == REQ_READ && rest_base < {1'b0, sample_min}) ?
                       {1'b0, sample_min} : rest_base;
   assign timer_inc  = timer_ff + TIMER_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      timer_in      = timer_ff;
      bit_index_in  = bit_index_ff;
      bit_total_in  = bit_total_ff;
      send_shift_in = send_shift_ff;
      receive_in    = receive_ff;
      op_kind_in    = op_kind_ff;
      rejected      = 1'b0;
      fin           = 1'b0;
      empty_done    = 1'b0;
      pin           = PIN_RELEASED;
      st            = ST_OK;
      phase_len     = (TIMER_W+1)'(1);
      index_inc     = bit_index_ff + BIT_COUNT_W'(1);

      // Start a command on the tick it arrives.
      if (phase_ff == PH_IDLE) begin
         if (item.req_type == REQ_RESET) begin
            op_kind_in = REQ_RESET;
            phase_in   = PH_RLOW;
            timer_in   = '0;
         end else if (item.req_type inside {REQ_WRITE, REQ_READ}) begin
            if (count_sat == '0) begin
               empty_done = 1'b1;
            end else begin
               op_kind_in    = item.req_type;
               bit_total_in  = count_sat;
               bit_index_in  = '0;
               send_shift_in = item.write_byte;
               receive_in    = '0;
               phase_in      = (cfg.recovery_ticks != 8'd0) ? PH_RECOVER : PH_LOW;
               timer_in      = '0;
            end
         end
      end else if (item.req_type != REQ_TICK) begin
         rejected = 1'b1;
      end

      if (!empty_done && phase_in != PH_IDLE) begin
         case (phase_in)
            PH_RECOVER: begin
               phase_len = (TIMER_W+1)'(cfg.recovery_ticks);
            end
            PH_LOW: begin
               pin       = PIN_LOW;
               phase_len = (TIMER_W+1)'(low_len);
            end
            PH_REST: begin
               phase_len = (TIMER_W+1)'(rest_len);
               if (op_kind_in == REQ_WRITE) begin
                  pin = send_shift_in[0] ? PIN_HIGH : PIN_RELEASED;
               end else if (timer_in == TIMER_W'(cfg.sample_delay_ticks) &&
                            bit_index_in < RX_LIMIT) begin
                  receive_in = receive_in | (BYTE_W'(item.bus_level) << bit_index_in[2:0]);
               end
            end
            PH_RLOW: begin
               pin       = PIN_LOW;
               phase_len = (cfg.reset_low_ticks == 10'd0) ? (TIMER_W+1)'(1) :
                           (TIMER_W+1)'(cfg.reset_low_ticks);
            end
            PH_RWAIT: begin
               phase_len = (TIMER_W+1)'(cfg.presence_delay_ticks) + (TIMER_W+1)'(1);
               // No device pulled the line low at the sample point.
               if (timer_in == TIMER_W'(cfg.presence_delay_ticks) && item.bus_level) begin
                  fin = 1'b1;
                  st  = ST_NO_PRESENCE;
               end
            end
            default: begin
               phase_len = (TIMER_W+1)'(cfg.reset_tail_ticks);
            end
         endcase

         timer_in = timer_inc;
         if (!fin && {1'b0, timer_inc} >= phase_len) begin
            timer_in = '0;
            case (phase_in)
               PH_RECOVER: phase_in = PH_LOW;
               PH_LOW:     phase_in = PH_REST;
               PH_REST: begin
                  send_shift_in = send_shift_in >> 1;
                  bit_index_in  = index_inc;
                  if (index_inc >= bit_total_in) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = (cfg.recovery_ticks != 8'd0) ? PH_RECOVER : PH_LOW;
                  end
               end
               PH_RLOW: phase_in = PH_RWAIT;
               PH_RWAIT: begin
                  if (cfg.reset_tail_ticks != 10'd0) begin
                     phase_in = PH_RTAIL;
                  end else begin
                     fin = 1'b1;
                  end
               end
               default: fin = 1'b1;
            endcase
         end
      end

      result = '0;
      if (empty_done) begin
         result.done_res = 1'b1;
      end else if (phase_in == PH_IDLE) begin
         result = '0;
      end else if (fin) begin
         phase_in         = PH_IDLE;
         timer_in         = '0;
         result.pin_mode  = pin;
         result.done_res  = 1'b1;
         result.read_byte = (op_kind_in == REQ_READ) ? receive_in : '0;
         result.status    = st;
      end else if (rejected) begin
         result.pin_mode = pin;
         result.busy_res = 1'b1;
         result.done_res = 1'b1;
         result.status   = ST_REJECTED;
      end else begin
         result.pin_mode = pin;
         result.busy_res = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         timer_ff      <= '0;
         bit_index_ff  <= '0;
         bit_total_ff  <= '0;
         send_shift_ff <= '0;
         receive_ff    <= '0;
         op_kind_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
         bit_index_ff  <= bit_index_in;
         bit_total_ff  <= bit_total_in;
         send_shift_ff <= send_shift_in;
         receive_ff    <= receive_in;
         op_kind_ff    <= op_kind_in;
      end
   end

endmodule

// File: src/onewire_bus_master.sv
// 1-Wire bus master sequencer, paced by tick transactions.
// req_if carries one transaction per bus tick: an optional command (bus reset,
// write or read of up to eight bits, least significant bit first) and the bus
// level sampled during that tick. rsp_if returns one transaction per tick with
// the pin mode to apply, busy and done flags, the read byte and a status code.
// The timing registers are written over the APB-style port; the user is to write
// them only while the block is idle, as the block does not enforce this. pready
// is always high and reads return the stored value. Each request transaction is
// taken into an input register, worked out combinationally by the sequencer,
// and its result lands in an output register. One transaction is taken every
// cycle while the receiver does not stall; the sequencer state is updated as
// each result is registered, which bounds the rate at one tick per clock.
// When the receiver stalls, the output register holds its result, the input
// register keeps at most one further request and, once that is held,
// req_if.ready stays low until the waiting result is taken.
// Synchronous reset returns the sequencer to idle, empties both registers and
// loads the default bus timing (standard speed slots of 60 ticks).
module onewire_bus_master import obm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   obm_req_if.sink               req_if,
   obm_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   req_item_type in_item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type out_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type step_result;
   logic         step;
   logic         accept;

   obm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign step          = in_valid_ff & (~out_valid_ff | rsp_if.ready);
   assign req_if.ready  = ~in_valid_ff | step;
   assign accept        = req_if.valid & req_if.ready;

   assign in_valid_in   = accept | (in_valid_ff & ~step);
   assign out_valid_in  = step | (out_valid_ff & ~rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.req_type   <= req_if.req_type;
         in_item_ff.bit_count  <= req_if.bit_count;
         in_item_ff.write_byte <= req_if.write_byte;
         in_item_ff.bus_level  <= req_if.bus_level;
      end
      if (step) begin
         out_item_ff <= step_result;
      end
   end

   obm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (step_result)
   );

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.pin_mode  = out_item_ff.pin_mode;
   assign rsp_if.busy_res  = out_item_ff.busy_res;
   assign rsp_if.done_res  = out_item_ff.done_res;
   assign rsp_if.read_byte = out_item_ff.read_byte;
   assign rsp_if.status    = out_item_ff.status;

endmodule
